// ===== hw/rtl/u8d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types and constants shared by the decoder's modules, and the value check of the front end.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_MULTI_CP   = 21'h0000A0;
    localparam logic [CP_W-1:0] SURR_LOW       = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HIGH      = 21'h00DFFF;
    localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
    localparam logic [CP_W-1:0] MIN_THREE_CP   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR_CP    = 21'h010000;

    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // One queue entry describes every result caused by one input word.
    // When two is set, a replacement precedes the result held in cp/rep.
    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp;
        logic            rep;
    } u8d_entry_t;

    typedef struct packed {
        logic       valid;
        u8d_entry_t entry;
    } u8d_push_t;

    typedef struct packed {
        logic       valid;
        u8d_entry_t entry;
    } u8d_head_t;

    function automatic logic value_is_bad(input logic [CP_W-1:0] cp,
                                          input logic [2:0] len);
        logic bad;
        bad = (cp < MIN_MULTI_CP)
            || ((cp >= SURR_LOW) && (cp <= SURR_HIGH))
            || ((len == LEN_THREE) && (cp < MIN_THREE_CP))
            || ((len == LEN_FOUR) && (cp < MIN_FOUR_CP))
            || (cp > MAX_CP);
        return bad;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/u8d_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the open sequence and queues the results of each byte.
// ----------------------------------------------------------------------------
module u8d_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       in_byte,
    output u8d_pkg::u8d_push_t    push
);
    import u8d_pkg::*;

    logic [1:0]      tails_left_reg, tails_left_next;
    logic [2:0]      seq_length_reg, seq_length_next;
    logic [CP_W-1:0] accum_value_reg, accum_value_next;
    logic            in_bad_run_reg, in_bad_run_next;

    logic            is_tail;
    logic            seq_open;
    logic [CP_W-1:0] accum_shift;
    logic [1:0]      tails_dec;
    logic            fresh_has;
    logic [CP_W-1:0] fresh_cp;
    logic            fresh_rep;
    logic            done_bad;

    always_comb
    begin
        is_tail     = (in_byte[7:6] == 2'b10);
        seq_open    = (tails_left_reg != 2'd0);
        accum_shift = {accum_value_reg[CP_W-7:0], in_byte[5:0]};
        tails_dec   = tails_left_reg - 2'd1;
        done_bad    = value_is_bad(accum_shift, seq_length_reg);

        tails_left_next  = tails_left_reg;
        seq_length_next  = seq_length_reg;
        accum_value_next = accum_value_reg;
        in_bad_run_next  = in_bad_run_reg;
        fresh_has        = 1'b0;
        fresh_cp         = REPLACEMENT_CP;
        fresh_rep        = 1'b1;
        push             = '0;

        if (seq_open && is_tail)
        begin
            tails_left_next  = tails_dec;
            accum_value_next = accum_shift;
            if (tails_dec == 2'd0)
            begin
                push.valid       = 1'b1;
                push.entry.two   = 1'b0;
                push.entry.cp    = done_bad ? REPLACEMENT_CP : accum_shift;
                push.entry.rep   = done_bad;
                seq_length_next  = 3'd0;
                accum_value_next = '0;
            end
        end
        else
        begin
            // A byte outside a sequence, or one that cuts an open sequence short.
            tails_left_next  = 2'd0;
            seq_length_next  = 3'd0;
            accum_value_next = '0;
            if (in_byte inside {[8'h00:8'h7F]})
            begin
                in_bad_run_next = 1'b0;
                fresh_has       = 1'b1;
                fresh_cp        = {{(CP_W-8){1'b0}}, in_byte};
                fresh_rep       = 1'b0;
            end
            else if (is_tail)
            begin
                in_bad_run_next = 1'b1;
                fresh_has       = !in_bad_run_reg;
            end
            else if (in_byte inside {[8'hC0:8'hDF]})
            begin
                in_bad_run_next  = 1'b0;
                accum_value_next = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                seq_length_next  = LEN_TWO;
                tails_left_next  = 2'd1;
            end
            else if (in_byte inside {[8'hE0:8'hEF]})
            begin
                in_bad_run_next  = 1'b0;
                accum_value_next = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                seq_length_next  = LEN_THREE;
                tails_left_next  = 2'd2;
            end
            else if (in_byte inside {[8'hF0:8'hF7]})
            begin
                in_bad_run_next  = 1'b0;
                accum_value_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                seq_length_next  = LEN_FOUR;
                tails_left_next  = 2'd3;
            end
            else
            begin
                in_bad_run_next = 1'b0;
                fresh_has       = 1'b1;
            end

            if (seq_open)
            begin
                push.valid     = 1'b1;
                push.entry.two = fresh_has;
                push.entry.cp  = fresh_has ? fresh_cp : REPLACEMENT_CP;
                push.entry.rep = fresh_has ? fresh_rep : 1'b1;
            end
            else
            begin
                push.valid     = fresh_has;
                push.entry.two = 1'b0;
                push.entry.cp  = fresh_cp;
                push.entry.rep = fresh_rep;
            end
        end

        if (!accept)
        begin
            push.valid       = 1'b0;
            tails_left_next  = tails_left_reg;
            seq_length_next  = seq_length_reg;
            accum_value_next = accum_value_reg;
            in_bad_run_next  = in_bad_run_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tails_left_reg  <= 2'd0;
            seq_length_reg  <= 3'd0;
            accum_value_reg <= '0;
            in_bad_run_reg  <= 1'b0;
        end
        else
        begin
            tails_left_reg  <= tails_left_next;
            seq_length_reg  <= seq_length_next;
            accum_value_reg <= accum_value_next;
            in_bad_run_reg  <= in_bad_run_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/u8d_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Short first-in first-out store between the front end and the output stage.
// ----------------------------------------------------------------------------
module u8d_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire u8d_pkg::u8d_push_t push,
    input  wire logic             pop,
    output logic                  full,
    output u8d_pkg::u8d_head_t    head
);
    import u8d_pkg::*;

    u8d_entry_t        store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
        head.valid  = (count_reg != '0);
        head.entry  = store[rd_ptr_reg];
        wr_ptr_next = push.valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            store[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/u8d_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder output stage
// Unpacks queue entries into one or two results and holds them for the sink.
// ----------------------------------------------------------------------------
module u8d_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire u8d_pkg::u8d_head_t       head,
    output logic                          pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [u8d_pkg::CP_W-1:0]      code_point,
    output logic                          replaced,
    output logic                          last_of_run
);
    import u8d_pkg::*;

    logic            valid_reg, valid_next;
    logic            phase_reg, phase_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            rep_reg, rep_next;
    logic            last_reg, last_next;
    logic            load;

    always_comb
    begin
        load       = !valid_reg || out_ready;
        valid_next = valid_reg && !out_ready;
        phase_next = phase_reg;
        cp_next    = cp_reg;
        rep_next   = rep_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (load && head.valid)
        begin
            valid_next = 1'b1;
            if (head.entry.two && !phase_reg)
            begin
                // The replacement for a broken sequence goes out first.
                phase_next = 1'b1;
                cp_next    = REPLACEMENT_CP;
                rep_next   = 1'b1;
                last_next  = 1'b0;
            end
            else
            begin
                phase_next = 1'b0;
                cp_next    = head.entry.cp;
                rep_next   = head.entry.rep;
                last_next  = 1'b1;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        rep_reg  <= rep_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign code_point  = cp_reg;
    assign replaced    = rep_reg;
    assign last_of_run = last_reg;

`ifndef NO_ASSERTIONS
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head.valid && head.entry.two))
        else $error("second half pending without its entry");

    a_phase_shown: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (valid_reg && !last_reg))
        else $error("first half of a pair not on the output");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (valid_reg && last_reg))
        else $error("popped entry did not close its run");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into Unicode code points with error replacement.
// ----------------------------------------------------------------------------
// Usage: one UTF-8 byte is taken per word on the s_ channel. Each byte gives
// zero, one or two code points on the m_ channel; m_tlast marks the final
// result caused by a byte, and m_tuser marks a U+FFFD replacement.
// A byte is accepted in every cycle while the four-entry result queue has
// room; it is classified and queued at the edge that accepts it, and its
// first result appears on m_ when the output register loads from the queue.
// A byte giving two results passes the output stage as two words, so while
// the sink is ready the rate is one byte per cycle but for broken sequences.
// When the sink stalls, the output register holds its word and the queue
// fills; s_tready falls only once the queue is full.
// Reset clears the sequence state, the queue and the output stage; a
// sequence left open emits nothing until a later byte closes it.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_tuser,   // [0] replaced
    output logic             m_tlast    // last_of_run
);
    import u8d_pkg::*;

    u8d_push_t       push;
    u8d_head_t       head;
    logic            full;
    logic            pop;
    logic            accept;
    logic [CP_W-1:0] code_point;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    u8d_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .push    (push)
    );

    u8d_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    u8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .code_point  (code_point),
        .replaced    (m_tuser),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {{(24-CP_W){1'b0}}, code_point};

endmodule
`default_nettype wire
